### rtl/core/svmrc_pkg.sv
// ----------------------------------------------------------------------------
// svmrc_pkg: shared constants of the stick merge radial clamp
// Fixed formats used by the merge and final clamp stages.
// ----------------------------------------------------------------------------
package svmrc_pkg;

  localparam int MERGE_FRAC = 8;
  localparam int MW = 26;

endpackage

### rtl/core/svmrc_div.sv
// ----------------------------------------------------------------------------
// svmrc_div: pipelined restoring divider
// One quotient bit per register stage, with a payload carried alongside.
// ----------------------------------------------------------------------------
module svmrc_div
  import svmrc_pkg::*;
#(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [PW-1:0] out_pay
);

  logic          vld [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] nm  [NW];
  logic [NW-1:0] q   [NW];
  logic [DW-1:0] dd  [NW];
  logic [PW-1:0] pp  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [DW-1:0] d_i;
    logic [NW-1:0] nm_i;
    logic [NW-1:0] q_i;
    logic [PW-1:0] p_i;
    logic [DW:0]   sh;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign d_i   = den;
      assign nm_i  = num;
      assign q_i   = '0;
      assign p_i   = in_pay;
    end else begin : g_next
      assign v_i   = vld[i-1];
      assign rem_i = rem[i-1];
      assign d_i   = dd[i-1];
      assign nm_i  = nm[i-1];
      assign q_i   = q[i-1];
      assign p_i   = pp[i-1];
    end

    assign sh = {rem_i, nm_i[NW-1]};
    assign ge = sh >= {1'b0, d_i};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i] <= ge ? DW'(sh - {1'b0, d_i}) : sh[DW-1:0];
        nm[i]  <= nm_i << 1;
        q[i]   <= {q_i[NW-2:0], ge};
        dd[i]  <= d_i;
        pp[i]  <= p_i;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = q[NW-1];
  assign out_pay   = pp[NW-1];

endmodule

### rtl/core/svmrc_sqrt.sv
// ----------------------------------------------------------------------------
// svmrc_sqrt: pipelined integer square root
// One root bit per register stage, floor result, payload carried alongside.
// ----------------------------------------------------------------------------
module svmrc_sqrt
  import svmrc_pkg::*;
#(
  parameter int VW = 64,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [VW-1:0]   val,
  input  logic [PW-1:0]   in_pay,
  output logic            out_valid,
  output logic [VW/2-1:0] root,
  output logic [PW-1:0]   out_pay
);

  localparam int HW = VW / 2;
  localparam int RW = HW + 3;

  logic          vld [HW];
  logic [RW-1:0] rem [HW];
  logic [HW-1:0] res [HW];
  logic [VW-1:0] vv  [HW];
  logic [PW-1:0] pp  [HW];

  for (genvar i = 0; i < HW; i++) begin : g_st
    logic          v_i;
    logic [RW-1:0] rem_i;
    logic [HW-1:0] res_i;
    logic [VW-1:0] vv_i;
    logic [PW-1:0] p_i;
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_i   = in_valid;
      assign rem_i = '0;
      assign res_i = '0;
      assign vv_i  = val;
      assign p_i   = in_pay;
    end else begin : g_next
      assign v_i   = vld[i-1];
      assign rem_i = rem[i-1];
      assign res_i = res[i-1];
      assign vv_i  = vv[i-1];
      assign p_i   = pp[i-1];
    end

    assign sh    = {rem_i[RW-3:0], vv_i[VW-1:VW-2]};
    assign trial = RW'({res_i, 2'b01});
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i] <= ge ? (sh - trial) : sh;
        res[i] <= {res_i[HW-2:0], ge};
        vv[i]  <= vv_i << 2;
        pp[i]  <= p_i;
      end
    end
  end

  assign out_valid = vld[HW-1];
  assign root      = res[HW-1];
  assign out_pay   = pp[HW-1];

endmodule

### rtl/core/stick_vector_merge_radial_clamp.sv
// ----------------------------------------------------------------------------
// stick_vector_merge_radial_clamp: stick merge with radial clamping
// Converts a velocity vector to a deflection, clamps it to the unit circle,
// adds it to the human stick and clamps the sum to the full-scale circle.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output is not stalled, and
// each yields one result; the block is a fully pipelined datapath of ratio
// dividers, square roots, clamp dividers and final dividers, one bit per
// stage, so a new transaction can enter while earlier ones are in flight. A
// stall on the output freezes the whole pipeline and nothing is lost.
module stick_vector_merge_radial_clamp
  import svmrc_pkg::*;
#(
  parameter int AXIS_FULL = 32767,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // human_x, human_y, vel_x, vel_y, full_gain_x, full_gain_y
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // merged_x, merged_y
  output logic [31:0]  m_tdata
);

  localparam int F    = FRAC_BITS;
  localparam int AW   = $clog2(AXIS_FULL + 1);
  localparam int QW   = 32 + F;
  localparam int SW   = $clog2(QW + 1);
  localparam int QS   = F + 2;
  localparam int PRW  = QS + AW;
  localparam int SH   = F - MERGE_FRAC;
  localparam int IW   = PRW - SH;
  localparam int AXW  = MW - 1;
  localparam int AAW  = AXW + AW;
  localparam int NW3  = AAW + 2;
  localparam int RW2  = 26;
  localparam logic [PRW-1:0] RC = (SH == 0) ? PRW'(0) : (PRW'(1) << (SH - 1));
  localparam logic [62:0] ONE2 = 63'(1) << (2 * F);
  localparam logic [50:0] FULL2 =
      51'((64'(AXIS_FULL) << MERGE_FRAC) * (64'(AXIS_FULL) << MERGE_FRAC));
  localparam logic [15:0] AXF = 16'(AXIS_FULL);

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic [15:0] hx_in, hy_in;
  logic [31:0] vx_in, vy_in, gx_in, gy_in, magx, magy;
  logic [QW-1:0] numx, numy;
  assign hx_in = s_tdata[15:0];
  assign hy_in = s_tdata[31:16];
  assign vx_in = s_tdata[63:32];
  assign vy_in = s_tdata[95:64];
  assign gx_in = s_tdata[127:96];
  assign gy_in = s_tdata[159:128];
  assign magx  = vx_in[31] ? (~vx_in + 32'd1) : vx_in;
  assign magy  = vy_in[31] ? (~vy_in + 32'd1) : vy_in;
  assign numx  = {magx, F'(0)} + QW'(gx_in >> 1);
  assign numy  = {magy, F'(0)} + QW'(gy_in >> 1);

  logic          d1_valid;
  logic [QW-1:0] d1_qx, d1_qy;
  logic [34:0]   d1_pay;
  logic [0:0]    d1_zy;

  svmrc_div #(.NW(QW), .DW(32), .PW(35)) u_ratio_x (
    .clk, .rst, .adv, .in_valid(s_tvalid && s_tready), .num(numx), .den(gx_in),
    .in_pay({hx_in, hy_in, vx_in[31], vy_in[31], gx_in == 32'd0}),
    .out_valid(d1_valid), .quo(d1_qx), .out_pay(d1_pay)
  );

  svmrc_div #(.NW(QW), .DW(32), .PW(1)) u_ratio_y (
    .clk, .rst, .adv, .in_valid(s_tvalid && s_tready), .num(numy), .den(gy_in),
    .in_pay(gy_in == 32'd0), .out_valid(), .quo(d1_qy), .out_pay(d1_zy)
  );

  // Stage N1: zero-gain override and shift amount.
  logic          n1_valid;
  logic [QW-1:0] n1_qx, n1_qy;
  logic [SW-1:0] n1_sh;
  logic [33:0]   n1_pay;
  logic [QW-1:0] rqx, rqy, rq_or;
  logic [SW-1:0] bitlen, sh_next;

  assign rqx   = d1_pay[0] ? '0 : d1_qx;
  assign rqy   = d1_zy[0] ? '0 : d1_qy;
  assign rq_or = rqx | rqy;

  always_comb begin
    bitlen = '0;
    for (int k = 0; k < QW; k++) begin
      if (rq_or[k]) begin
        bitlen = SW'(k + 1);
      end
    end
    sh_next = (bitlen > SW'(31)) ? (bitlen - SW'(31)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_valid <= 1'b0;
    end else if (adv) begin
      n1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_qx  <= rqx;
      n1_qy  <= rqy;
      n1_sh  <= sh_next;
      n1_pay <= d1_pay[34:1];
    end
  end

  // Stage N2: joint shift below 2^31.
  logic        n2_valid;
  logic [30:0] n2_qx, n2_qy;
  logic [33:0] n2_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_valid <= 1'b0;
    end else if (adv) begin
      n2_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n2_qx  <= 31'(n1_qx >> n1_sh);
      n2_qy  <= 31'(n1_qy >> n1_sh);
      n2_pay <= n1_pay;
    end
  end

  // Stage M: squares.
  logic        m_valid;
  logic [30:0] m_qx, m_qy;
  logic [61:0] m_sqx, m_sqy;
  logic [33:0] m_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_sqx <= 62'(n2_qx) * 62'(n2_qx);
      m_sqy <= 62'(n2_qy) * 62'(n2_qy);
      m_qx  <= n2_qx;
      m_qy  <= n2_qy;
      m_pay <= n2_pay;
    end
  end

  logic [62:0] a_s2;
  logic        a_cl;
  assign a_s2 = 63'(m_sqx) + 63'(m_sqy);
  assign a_cl = a_s2 > ONE2;

  logic        r1_valid;
  logic [31:0] r1_root;
  logic [96:0] r1_pay;

  svmrc_sqrt #(.VW(64), .PW(97)) u_sqrt_ratio (
    .clk, .rst, .adv, .in_valid(m_valid), .val({1'b0, a_s2}),
    .in_pay({m_qx, m_qy, a_cl, m_pay}),
    .out_valid(r1_valid), .root(r1_root), .out_pay(r1_pay)
  );

  logic [30:0]   r1_qx, r1_qy;
  logic          r1_cl;
  logic [33:0]   r1_rest;
  logic [QW-1:0] num2x, num2y;
  assign {r1_qx, r1_qy, r1_cl, r1_rest} = r1_pay;
  assign num2x = QW'({r1_qx, F'(0)}) + QW'(r1_root >> 1);
  assign num2y = QW'({r1_qy, F'(0)}) + QW'(r1_root >> 1);

  logic          d2_valid;
  logic [QW-1:0] d2_qx, d2_qy;
  logic [F+35:0] d2_pay;
  logic [F:0]    d2_qyl;

  svmrc_div #(.NW(QW), .DW(32), .PW(F + 36)) u_clamp_x (
    .clk, .rst, .adv, .in_valid(r1_valid), .num(num2x), .den(r1_root),
    .in_pay({r1_qx[F:0], r1_cl, r1_rest}),
    .out_valid(d2_valid), .quo(d2_qx), .out_pay(d2_pay)
  );

  svmrc_div #(.NW(QW), .DW(32), .PW(F + 1)) u_clamp_y (
    .clk, .rst, .adv, .in_valid(r1_valid), .num(num2y), .den(r1_root),
    .in_pay(r1_qy[F:0]), .out_valid(), .quo(d2_qy), .out_pay(d2_qyl)
  );

  // Stage P: select clamped ratio and scale by full deflection.
  logic           p_valid;
  logic [PRW-1:0] p_px, p_py;
  logic [33:0]    p_pay;
  logic [QS-1:0]  sel_qx, sel_qy;
  logic           d2_cl;
  assign d2_cl  = d2_pay[34];
  assign sel_qx = d2_cl ? d2_qx[QS-1:0] : {1'b0, d2_pay[F+35:35]};
  assign sel_qy = d2_cl ? d2_qy[QS-1:0] : {1'b0, d2_qyl};

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_px  <= PRW'(sel_qx) * PRW'(AXIS_FULL);
      p_py  <= PRW'(sel_qy) * PRW'(AXIS_FULL);
      p_pay <= d2_pay[33:0];
    end
  end

  // Stage I: injection rounding and merge with the human stick.
  logic              i_valid;
  logic signed [MW-1:0] i_mx, i_my;
  logic [PRW-1:0]    ipx, ipy;
  logic [MW-1:0]     ix, iy;
  logic signed [MW-1:0] hxm, hym;
  logic [15:0]       p_hx, p_hy;
  logic              p_nx, p_ny;
  assign {p_hx, p_hy, p_nx, p_ny} = p_pay;
  assign ipx = (p_px + RC) >> SH;
  assign ipy = (p_py + RC) >> SH;
  assign ix  = MW'(ipx[IW-1:0]);
  assign iy  = MW'(ipy[IW-1:0]);
  assign hxm = MW'($signed(p_hx)) <<< MERGE_FRAC;
  assign hym = MW'($signed(p_hy)) <<< MERGE_FRAC;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (adv) begin
      i_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_mx <= p_nx ? (hxm - $signed(ix)) : (hxm + $signed(ix));
      i_my <= p_ny ? (hym - $signed(iy)) : (hym + $signed(iy));
    end
  end

  // Stage B: magnitudes.
  logic           b_valid;
  logic [AXW-1:0] b_ax, b_ay;
  logic           b_nx, b_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_ax <= i_mx[MW-1] ? AXW'(-i_mx) : AXW'(i_mx);
      b_ay <= i_my[MW-1] ? AXW'(-i_my) : AXW'(i_my);
      b_nx <= i_mx[MW-1];
      b_ny <= i_my[MW-1];
    end
  end

  // Stage C: squares and scaled magnitudes.
  logic           c_valid;
  logic [49:0]    c_sqx, c_sqy;
  logic [AAW-1:0] c_axa, c_aya;
  logic [AXW-1:0] c_ax, c_ay;
  logic           c_nx, c_ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_sqx <= 50'(b_ax) * 50'(b_ax);
      c_sqy <= 50'(b_ay) * 50'(b_ay);
      c_axa <= AAW'(b_ax) * AAW'(AXIS_FULL);
      c_aya <= AAW'(b_ay) * AAW'(AXIS_FULL);
      c_ax  <= b_ax;
      c_ay  <= b_ay;
      c_nx  <= b_nx;
      c_ny  <= b_ny;
    end
  end

  logic [50:0] c_s2;
  logic        c_cl;
  assign c_s2 = 51'(c_sqx) + 51'(c_sqy);
  assign c_cl = c_s2 > FULL2;

  localparam int P2W = 2 * AAW + 2 * AXW + 3;

  logic           r2_valid;
  logic [RW2-1:0] r2_root;
  logic [P2W-1:0] r2_pay;

  svmrc_sqrt #(.VW(52), .PW(P2W)) u_sqrt_merge (
    .clk, .rst, .adv, .in_valid(c_valid), .val({1'b0, c_s2}),
    .in_pay({c_axa, c_aya, c_ax, c_ay, c_cl, c_nx, c_ny}),
    .out_valid(r2_valid), .root(r2_root), .out_pay(r2_pay)
  );

  logic [AAW-1:0] r2_axa, r2_aya;
  logic [AXW-1:0] r2_ax, r2_ay;
  logic           r2_cl, r2_nx, r2_ny;
  logic [NW3-1:0] num3x, num3y;
  assign {r2_axa, r2_aya, r2_ax, r2_ay, r2_cl, r2_nx, r2_ny} = r2_pay;
  assign num3x = NW3'({r2_axa, 1'b0}) + NW3'(r2_root);
  assign num3y = NW3'({r2_aya, 1'b0}) + NW3'(r2_root);

  logic           d3_valid;
  logic [NW3-1:0] d3_ox, d3_oy;
  logic [AXW+2:0] d3_pay;
  logic [AXW-1:0] d3_ay;

  svmrc_div #(.NW(NW3), .DW(RW2 + 1), .PW(AXW + 3)) u_final_x (
    .clk, .rst, .adv, .in_valid(r2_valid), .num(num3x), .den({r2_root, 1'b0}),
    .in_pay({r2_ax, r2_cl, r2_nx, r2_ny}),
    .out_valid(d3_valid), .quo(d3_ox), .out_pay(d3_pay)
  );

  svmrc_div #(.NW(NW3), .DW(RW2 + 1), .PW(AXW)) u_final_y (
    .clk, .rst, .adv, .in_valid(r2_valid), .num(num3y), .den({r2_root, 1'b0}),
    .in_pay(r2_ay), .out_valid(), .quo(d3_oy), .out_pay(d3_ay)
  );

  // Output register.
  logic [AXW-1:0] f_ax;
  logic           f_cl, f_nx, f_ny;
  logic [15:0]    ox, oy;
  logic [AXW-1:0] rax, ray;
  assign {f_ax, f_cl, f_nx, f_ny} = d3_pay;
  assign rax = (f_ax + AXW'(1 << (MERGE_FRAC - 1))) >> MERGE_FRAC;
  assign ray = (d3_ay + AXW'(1 << (MERGE_FRAC - 1))) >> MERGE_FRAC;

  always_comb begin
    if (f_cl) begin
      ox = (d3_ox > NW3'(AXIS_FULL)) ? AXF : 16'(d3_ox);
      oy = (d3_oy > NW3'(AXIS_FULL)) ? AXF : 16'(d3_oy);
    end else begin
      ox = 16'(rax);
      oy = 16'(ray);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {f_ny ? (16'd0 - oy) : oy, f_nx ? (16'd0 - ox) : ox};
    end
  end

  a_out_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed(AXF)) &&
                 ($signed(m_tdata[15:0]) >= -$signed(AXF)))
    else $error("merged_x beyond full scale");

  a_out_y_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed(AXF)) &&
                 ($signed(m_tdata[31:16]) >= -$signed(AXF)))
    else $error("merged_y beyond full scale");

  a_unit_ratio: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !a_cl) |-> (32'(m_qx) <= (32'(1) << F)) && (32'(m_qy) <= (32'(1) << F)))
    else $error("unclamped ratio outside the unit circle");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule
